/* hw/rtl/image_rotate_nearest_top_defines.svh */
// Assertion macros for the image rotation RTL.
`ifndef IMAGE_ROTATE_NEAREST_TOP_DEFINES_SVH
`define IMAGE_ROTATE_NEAREST_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled during rst.
`define IRN_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk and disabled during rst.
`define IRN_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* hw/rtl/irn_pkg.sv */
// Types and constants for the nearest-neighbor image rotation block.
package irn_pkg;

  localparam int MAX_SIDE_DEF   = 64;
  localparam int ANGLE_BITS_DEF = 16;

  localparam int SIDE_W     = 7;
  localparam int POS_W      = 6;
  localparam int PIX_W      = 32;
  localparam int STEP_W     = 16;
  localparam int TRIG_W     = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [1:0] OP_LOAD    = 2'd0;
  localparam logic [1:0] OP_ADVANCE = 2'd1;
  localparam logic [1:0] OP_RENDER  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP   = 2'd2;

  // Polynomial coefficients for the quarter-wave sine, Q15.
  localparam logic [16:0] K_A = 17'd51472;
  localparam logic [16:0] K_B = 17'd21024;
  localparam logic [16:0] K_C = 17'd2320;
  localparam logic [16:0] SAT_MAX = 17'd32767;
  localparam logic [14:0] QUARTER = 15'd16384;

  localparam logic [TRIG_W-1:0] COS_RESET = 16'h7FFF;

  localparam int DIV_STEPS = 21;
  localparam int DIV_CNT_W = 5;
  localparam int MUL_A_W   = 34;
  localparam int MUL_B_W   = 18;
  localparam int PROD_W    = 52;
  localparam int Q30_W     = 33;
  localparam int STEP_CW   = 3;

  typedef struct packed {
    logic [1:0]       opcode;
    logic [POS_W-1:0] column;
    logic [POS_W-1:0] row;
    logic [PIX_W-1:0] pixel_in;
  } irn_item_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_out;
    logic             outside;
  } irn_result_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_ADV,
    ST_TRIG,
    ST_DIV,
    ST_MUL,
    ST_READ,
    ST_OUT
  } irn_state_t;

endpackage

/* hw/rtl/irn_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module irn_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* hw/rtl/image_rotate_nearest_top.sv */
// Load: a pixel inside the image is written to the source. Advance: an add, then two 5-step sine
// passes. Render inside the image: two restoring divisions by the image sizes, seven multiplier
// passes and one read, with no read when the rotated sample misses the source. One item at a
// time; a result waits in an output register.
// Reset is synchronous: sizes 32, step 104, angle 0, sine 0, cosine 32767, outputs empty.
// The source memory is not cleared by reset.
module image_rotate_nearest_top #(
  parameter int MAX_SIDE   = irn_pkg::MAX_SIDE_DEF,
  parameter int ANGLE_BITS = irn_pkg::ANGLE_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                req_valid,
  output logic                                req_ready,
  input  irn_pkg::irn_item_t                  req_item,
  output logic                                rsp_valid,
  input  logic                                rsp_ready,
  output irn_pkg::irn_result_t                rsp_item,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [irn_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [irn_pkg::CFG_DATA_W-1:0]      cfg_data
);

  import irn_pkg::*;

  localparam int DEPTH = MAX_SIDE * MAX_SIDE;
  localparam int AW    = $clog2(DEPTH);

  localparam logic [STEP_CW-1:0] LOAD_LAST = 3'd1;
  localparam logic [STEP_CW-1:0] TRIG_LAST = 3'd4;
  localparam logic [STEP_CW-1:0] MUL_LAST  = 3'd6;
  localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_STEPS - 1);

  localparam logic signed [PROD_W-1:0] TRUNC_BIAS = PROD_W'((64'd1 << 30) - 64'd1);
  localparam logic signed [Q30_W-1:0]  HALF_Q30   = Q30_W'(64'd1 << 29);

  irn_state_t state, state_next;
  logic [STEP_CW-1:0] step;

  logic [SIDE_W-1:0]     image_width, image_height;
  logic [STEP_W-1:0]     angle_step;
  logic [ANGLE_BITS-1:0] angle_acc;
  logic signed [TRIG_W-1:0] sine, cosine;

  logic [SIDE_W-1:0] wc, hc;
  logic req_fire;

  // Latched item.
  logic [POS_W-1:0] col_r, row_r;
  logic [PIX_W-1:0] pix_r;

  // Shared multiplier.
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  prod;

  // Trig datapath.
  logic [ANGLE_BITS+15:0] phase_ext;
  logic [15:0] phase;
  logic [1:0]  quad;
  logic [14:0] xq, xv;
  logic [15:0] z;
  logic [16:0] p_hi, t1, t2;
  logic [TRIG_W-1:0] sat_val;
  logic trig_sel;
  logic [TRIG_W-1:0] s_val;
  logic [15:0] z2_r;
  logic [ANGLE_BITS+STEP_W-1:0] step_wide;

  // Divider.
  logic signed [8:0] dx_diff, dy_diff, dx_abs, dy_abs;
  logic div_sel, div_neg;
  logic [DIV_CNT_W-1:0] div_cnt;
  logic [SIDE_W-1:0] rem_r, div_d;
  logic [DIV_STEPS-1:0] qn, quo;
  logic [SIDE_W:0] trial;
  logic ge;
  logic [SIDE_W:0] trial_sub;

  // Render datapath.
  logic signed [TRIG_W-1:0] dx, dy;
  logic signed [Q30_W-1:0]  acc_r, nx_r, ny_r;
  logic signed [PROD_W-1:0] prod_bias;
  logic signed [9:0]  qv, sc_r;
  logic signed [10:0] sr;
  logic sc_ok, sr_ok, in_image;
  logic res_outside;

  // Memory.
  logic ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [PIX_W-1:0] ram_rdata;

  assign req_ready = (state == ST_IDLE);
  assign req_fire  = req_valid && req_ready;
  assign cfg_ready = 1'b1;

  // A size of zero acts as one and sizes above the memory side saturate.
  always_comb begin
    if (image_width == '0) begin
      wc = SIDE_W'(1);
    end else if (int'(image_width) > MAX_SIDE) begin
      wc = SIDE_W'(MAX_SIDE);
    end else begin
      wc = image_width;
    end
    if (image_height == '0) begin
      hc = SIDE_W'(1);
    end else if (int'(image_height) > MAX_SIDE) begin
      hc = SIDE_W'(MAX_SIDE);
    end else begin
      hc = image_height;
    end
  end

  assign in_image = (SIDE_W'(req_item.column) < wc) && (SIDE_W'(req_item.row) < hc);

  // The phase is the top 16 bits of the accumulator, zero-padded below when it is narrower.
  assign phase_ext = {angle_acc, 16'h0000};
  assign phase     = phase_ext[ANGLE_BITS+15 -: 16];
  assign quad      = phase[15:14];
  assign xq        = {1'b0, phase[13:0]};
  assign xv        = trig_sel ? (QUARTER - xq) : xq;
  assign z         = {xv, 1'b0};
  assign p_hi      = prod[31:15];
  assign t1        = K_B - p_hi;
  assign t2        = K_A - p_hi;
  assign sat_val   = (p_hi > SAT_MAX) ? COS_RESET : p_hi[15:0];
  assign step_wide = {{ANGLE_BITS{1'b0}}, angle_step};

  assign dx_diff = $signed({2'b00, req_item.column, 1'b1}) - $signed({2'b00, wc});
  assign dy_diff = $signed({2'b00, hc}) - $signed({2'b00, row_r, 1'b1});
  assign dx_abs  = dx_diff[8] ? -dx_diff : dx_diff;
  assign dy_abs  = dy_diff[8] ? -dy_diff : dy_diff;

  assign div_d     = div_sel ? hc : wc;
  assign trial     = {rem_r, qn[DIV_STEPS-1]};
  assign ge        = trial >= {1'b0, div_d};
  assign trial_sub = trial - {1'b0, div_d};
  assign quo       = {qn[DIV_STEPS-2:0], ge};

  // Division by 2^30 truncating toward zero.
  assign prod_bias = prod + (prod[PROD_W-1] ? TRUNC_BIAS : '0);
  assign qv        = prod_bias[39:30];
  assign sr        = $signed({4'b0000, hc}) - 11'sd1 - $signed({qv[9], qv});
  assign sc_ok     = !sc_r[9] && (sc_r < $signed({3'b000, wc}));
  assign sr_ok     = !sr[10] && (sr < $signed({4'b0000, hc}));

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      ST_LOAD: begin
        mul_a = MUL_A_W'(row_r);
        mul_b = MUL_B_W'(wc);
      end
      ST_TRIG: begin
        case (step)
          3'd0: begin
            mul_a = MUL_A_W'(z);
            mul_b = MUL_B_W'(z);
          end
          3'd1: begin
            mul_a = MUL_A_W'(K_C);
            mul_b = MUL_B_W'(p_hi);
          end
          3'd2: begin
            mul_a = MUL_A_W'(z2_r);
            mul_b = MUL_B_W'(t1);
          end
          3'd3: begin
            mul_a = MUL_A_W'(z);
            mul_b = MUL_B_W'(t2);
          end
          default: ;
        endcase
      end
      ST_MUL: begin
        case (step)
          3'd0: begin
            mul_a = MUL_A_W'(dx);
            mul_b = MUL_B_W'(cosine);
          end
          3'd1: begin
            mul_a = MUL_A_W'(dy);
            mul_b = MUL_B_W'(sine);
          end
          3'd2: begin
            mul_a = MUL_A_W'(dy);
            mul_b = MUL_B_W'(cosine);
          end
          3'd3: begin
            mul_a = MUL_A_W'(dx);
            mul_b = MUL_B_W'(sine);
          end
          3'd4: begin
            mul_a = MUL_A_W'(nx_r + HALF_Q30);
            mul_b = MUL_B_W'(wc);
          end
          3'd5: begin
            mul_a = MUL_A_W'(ny_r + HALF_Q30);
            mul_b = MUL_B_W'(hc);
          end
          3'd6: begin
            mul_a = MUL_A_W'(sr);
            mul_b = MUL_B_W'(wc);
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (req_fire) begin
          case (req_item.opcode)
            OP_LOAD:    state_next = in_image ? ST_LOAD : ST_IDLE;
            OP_ADVANCE: state_next = ST_ADV;
            OP_RENDER:  state_next = in_image ? ST_DIV : ST_OUT;
            default:    state_next = ST_IDLE;
          endcase
        end
      end
      ST_LOAD: begin
        if (step == LOAD_LAST) state_next = ST_IDLE;
      end
      ST_ADV: state_next = ST_TRIG;
      ST_TRIG: begin
        if (step == TRIG_LAST && trig_sel) state_next = ST_IDLE;
      end
      ST_DIV: begin
        if (div_cnt == DIV_LAST && div_sel) state_next = ST_MUL;
      end
      ST_MUL: begin
        if (step == MUL_LAST) state_next = (sc_ok && sr_ok) ? ST_READ : ST_OUT;
      end
      ST_READ: state_next = ST_OUT;
      ST_OUT: begin
        if (!rsp_valid || rsp_ready) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assign ram_we    = (state == ST_LOAD) && (step == LOAD_LAST);
  assign ram_waddr = prod[AW-1:0] + AW'(col_r);
  assign ram_re    = (state == ST_READ);
  assign ram_raddr = prod[AW-1:0] + AW'($unsigned(sc_r));

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    if (rst) begin
      state        <= ST_IDLE;
      step         <= '0;
      image_width  <= SIDE_W'(32);
      image_height <= SIDE_W'(32);
      angle_step   <= STEP_W'(104);
      angle_acc    <= '0;
      sine         <= '0;
      cosine       <= COS_RESET;
      rsp_valid    <= 1'b0;
      trig_sel     <= 1'b0;
      div_sel      <= 1'b0;
      div_cnt      <= '0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_WIDTH:  image_width  <= cfg_data[SIDE_W-1:0];
          CFG_HEIGHT: image_height <= cfg_data[SIDE_W-1:0];
          CFG_STEP:   angle_step   <= cfg_data[STEP_W-1:0];
          default: ;
        endcase
      end
      if (rsp_valid && rsp_ready && (state != ST_OUT)) rsp_valid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (req_fire) begin
            col_r       <= req_item.column;
            row_r       <= req_item.row;
            pix_r       <= req_item.pixel_in;
            step        <= '0;
            div_cnt     <= '0;
            div_sel     <= 1'b0;
            rem_r       <= '0;
            qn          <= {dx_abs[6:0], 14'd0};
            div_neg     <= dx_diff[8];
            res_outside <= 1'b1;
          end
        end
        ST_LOAD: step <= step + 3'd1;
        ST_ADV: begin
          angle_acc <= angle_acc + step_wide[ANGLE_BITS-1:0];
          step      <= '0;
          trig_sel  <= 1'b0;
        end
        ST_TRIG: begin
          if (step == 3'd1) z2_r <= p_hi[15:0];
          if (step == TRIG_LAST) begin
            step <= '0;
            if (!trig_sel) begin
              s_val    <= sat_val;
              trig_sel <= 1'b1;
            end else begin
              // sat_val now holds the cosine of the quarter-turn position.
              case (quad)
                2'd0: begin
                  sine   <= s_val;
                  cosine <= sat_val;
                end
                2'd1: begin
                  sine   <= sat_val;
                  cosine <= -s_val;
                end
                2'd2: begin
                  sine   <= -s_val;
                  cosine <= -sat_val;
                end
                default: begin
                  sine   <= -sat_val;
                  cosine <= s_val;
                end
              endcase
            end
          end else begin
            step <= step + 3'd1;
          end
        end
        ST_DIV: begin
          if (div_cnt == DIV_LAST) begin
            div_cnt <= '0;
            if (!div_sel) begin
              dx      <= div_neg ? -quo[15:0] : quo[15:0];
              div_sel <= 1'b1;
              rem_r   <= '0;
              qn      <= {dy_abs[6:0], 14'd0};
              div_neg <= dy_diff[8];
            end else begin
              dy   <= div_neg ? -quo[15:0] : quo[15:0];
              step <= '0;
            end
          end else begin
            rem_r   <= ge ? trial_sub[SIDE_W-1:0] : trial[SIDE_W-1:0];
            qn      <= quo;
            div_cnt <= div_cnt + DIV_CNT_W'(1);
          end
        end
        ST_MUL: begin
          step <= step + 3'd1;
          case (step)
            3'd1: acc_r <= Q30_W'(prod);
            3'd2: nx_r  <= acc_r + Q30_W'(prod);
            3'd3: acc_r <= Q30_W'(prod);
            3'd4: ny_r  <= acc_r - Q30_W'(prod);
            3'd5: sc_r  <= qv;
            default: ;
          endcase
        end
        ST_READ: res_outside <= 1'b0;
        ST_OUT: begin
          if (!rsp_valid || rsp_ready) begin
            rsp_valid          <= 1'b1;
            rsp_item.outside   <= res_outside;
            rsp_item.pixel_out <= res_outside ? '0 : ram_rdata;
          end
        end
        default: ;
      endcase
    end
  end

  irn_ram #(
    .WIDTH(PIX_W),
    .DEPTH(DEPTH)
  ) u_source (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(pix_r),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

`include "image_rotate_nearest_top_defines.svh"

  `IRN_ASSERT_NEXT(a_render_busy, req_fire && (req_item.opcode == OP_RENDER), !req_ready, "render accepted but block ready next cycle")
  `IRN_ASSERT_SAME(a_outside_zero, rsp_valid && rsp_item.outside, rsp_item.pixel_out == '0, "outside result carries a nonzero pixel")
  `IRN_ASSERT_SAME(a_trig_nonzero, 1'b1, !((sine == '0) && (cosine == '0)), "sine and cosine both zero")
  `IRN_ASSERT_SAME(a_div_bound, state == ST_DIV, div_cnt <= DIV_LAST, "divider ran past its last step")

endmodule
